[hw/rtl/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge, silent while reset is held
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/i2cm_pkg.sv]
`default_nettype none
package i2cm_pkg;

  localparam int BYTE_BITS   = 8;
  localparam int LIMIT_W     = 15;
  localparam int WAIT_W      = 16;
  localparam int BITS_W      = 4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1000);
  localparam logic [BITS_W-1:0]  BITS_FULL   = BITS_W'(BYTE_BITS);

  // command / operation codes
  localparam logic [2:0] OP_IDLE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;
  localparam logic [2:0] OP_WAIT  = 3'd5;

  // phase numbers within an operation
  localparam logic [2:0] PH_0 = 3'd0;
  localparam logic [2:0] PH_1 = 3'd1;
  localparam logic [2:0] PH_2 = 3'd2;
  localparam logic [2:0] PH_3 = 3'd3;
  localparam logic [2:0] PH_4 = 3'd4;
  localparam logic [2:0] PH_5 = 3'd5;
  localparam logic [2:0] PH_6 = 3'd6;
  localparam logic [2:0] PH_7 = 3'd7;

  typedef struct packed {
    logic [2:0]           cmd;
    logic [BYTE_BITS-1:0] write_byte;
    logic                 send_ack;
    logic                 sda_sample;
  } item_t;

  typedef struct packed {
    logic                 scl_level;
    logic                 sda_level;
    logic                 sda_drive;
    logic                 busy_res;
    logic                 done_res;
    logic [BYTE_BITS-1:0] read_byte;
    logic                 ack_missing;
  } result_t;

  typedef struct packed {
    logic [2:0]           op;
    logic [2:0]           phase;
    logic [BITS_W-1:0]    bits_left;
    logic [BYTE_BITS-1:0] shift_byte;
    logic [WAIT_W-1:0]    wait_count;
    logic                 ack_choice;
    logic                 scl;
    logic                 sda;
    logic                 drv;
    logic [BYTE_BITS-1:0] last_read;
    logic                 stop_fail;
  } seq_state_t;

endpackage
`default_nettype wire

[hw/rtl/i2cm_in_stage.sv]
`default_nettype none
module i2cm_in_stage import i2cm_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire item_t in_item,
  input  wire logic  step,
  output logic       item_valid,
  output item_t      item
);

  logic  valid_r;
  item_t item_r;

  // holds the item until the engine takes it
  assign in_stall   = valid_r && !step;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      valid_r <= 1'b1;
    end else if (step) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_item;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/i2cm_phase_engine.sv]
`default_nettype none
module i2cm_phase_engine import i2cm_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire item_t               item,
  input  wire logic                cfg_we,
  input  wire logic [LIMIT_W-1:0]  cfg_data,
  output result_t                  res
);

  seq_state_t         st_r, st_nxt;
  logic [LIMIT_W-1:0] limit_r;
  logic               done;
  logic               missing;
  logic [BITS_W-1:0]  bits_dec;
  logic [WAIT_W-1:0]  wait_inc;

  always_comb begin
    st_nxt   = st_r;
    done     = 1'b0;
    missing  = 1'b0;
    bits_dec = '0;
    wait_inc = '0;

    // launch a new command only when idle
    if (st_r.op == OP_IDLE && item.cmd >= OP_START && item.cmd <= OP_WAIT) begin
      st_nxt.op        = item.cmd;
      st_nxt.phase     = PH_0;
      st_nxt.stop_fail = 1'b0;
      if (item.cmd == OP_WRITE) begin
        st_nxt.shift_byte = item.write_byte;
        st_nxt.bits_left  = BITS_FULL;
      end else if (item.cmd == OP_READ) begin
        st_nxt.shift_byte = '0;
        st_nxt.bits_left  = BITS_FULL;
        st_nxt.ack_choice = item.send_ack;
      end else if (item.cmd == OP_WAIT) begin
        st_nxt.wait_count = '0;
      end
    end

    bits_dec = (st_nxt.bits_left != '0) ? st_nxt.bits_left - 1'b1 : st_nxt.bits_left;
    wait_inc = st_nxt.wait_count + 1'b1;

    unique case (st_nxt.op)
      OP_START: begin
        unique case (st_nxt.phase)
          PH_0:    begin st_nxt.sda = 1'b1; st_nxt.phase = PH_1; end
          PH_1:    begin st_nxt.scl = 1'b1; st_nxt.phase = PH_2; end
          PH_2:    begin st_nxt.sda = 1'b0; st_nxt.phase = PH_3; end
          default: begin st_nxt.scl = 1'b0; done = 1'b1; end
        endcase
      end
      OP_STOP: begin
        unique case (st_nxt.phase)
          PH_0: begin
            st_nxt.drv   = 1'b1;
            st_nxt.sda   = 1'b0;
            st_nxt.phase = PH_1;
          end
          PH_1:    begin st_nxt.scl = 1'b0; st_nxt.phase = PH_2; end
          PH_2:    begin st_nxt.sda = 1'b1; st_nxt.phase = PH_3; end
          default: begin
            st_nxt.scl = 1'b1;
            missing    = st_nxt.stop_fail;
            done       = 1'b1;
          end
        endcase
      end
      OP_WRITE: begin
        unique case (st_nxt.phase)
          PH_0: begin
            st_nxt.drv   = 1'b1;
            st_nxt.scl   = 1'b0;
            st_nxt.phase = PH_1;
          end
          PH_1: begin
            st_nxt.sda        = st_nxt.shift_byte[BYTE_BITS-1];
            st_nxt.shift_byte = {st_nxt.shift_byte[BYTE_BITS-2:0], 1'b0};
            st_nxt.phase      = PH_2;
          end
          PH_2: begin st_nxt.scl = 1'b1; st_nxt.phase = PH_3; end
          default: begin
            st_nxt.scl       = 1'b0;
            st_nxt.bits_left = bits_dec;
            if (bits_dec == '0) begin
              done = 1'b1;
            end else begin
              st_nxt.phase = PH_1;
            end
          end
        endcase
      end
      OP_READ: begin
        unique case (st_nxt.phase)
          PH_0: begin st_nxt.drv = 1'b0; st_nxt.phase = PH_1; end
          PH_1: begin st_nxt.scl = 1'b0; st_nxt.phase = PH_2; end
          PH_2: begin
            st_nxt.scl        = 1'b1;
            st_nxt.shift_byte = {st_nxt.shift_byte[BYTE_BITS-2:0], item.sda_sample};
            st_nxt.bits_left  = bits_dec;
            st_nxt.phase      = (bits_dec == '0) ? PH_3 : PH_1;
          end
          PH_3: begin st_nxt.scl = 1'b0; st_nxt.phase = PH_4; end
          PH_4: begin st_nxt.drv = 1'b1; st_nxt.phase = PH_5; end
          PH_5: begin st_nxt.sda = !st_nxt.ack_choice; st_nxt.phase = PH_6; end
          PH_6: begin st_nxt.scl = 1'b1; st_nxt.phase = PH_7; end
          default: begin
            st_nxt.scl       = 1'b0;
            st_nxt.last_read = st_nxt.shift_byte;
            done             = 1'b1;
          end
        endcase
      end
      OP_WAIT: begin
        unique case (st_nxt.phase)
          PH_0: begin st_nxt.drv = 1'b0; st_nxt.phase = PH_1; end
          PH_1: begin st_nxt.sda = 1'b1; st_nxt.phase = PH_2; end
          PH_2: begin st_nxt.scl = 1'b1; st_nxt.phase = PH_3; end
          PH_3: begin
            if (!item.sda_sample) begin
              st_nxt.phase = PH_4;
            end else begin
              st_nxt.wait_count = wait_inc;
              // timeout hands over to a stop sequence
              if (wait_inc > {1'b0, limit_r}) begin
                st_nxt.op        = OP_STOP;
                st_nxt.phase     = PH_0;
                st_nxt.stop_fail = 1'b1;
              end
            end
          end
          default: begin st_nxt.scl = 1'b0; done = 1'b1; end
        endcase
      end
      default: begin
        st_nxt.op = OP_IDLE;
      end
    endcase

    if (done) begin
      st_nxt.op        = OP_IDLE;
      st_nxt.phase     = PH_0;
      st_nxt.stop_fail = 1'b0;
    end

    res.scl_level   = st_nxt.scl;
    res.sda_level   = st_nxt.sda;
    res.sda_drive   = st_nxt.drv;
    res.busy_res    = (st_nxt.op != OP_IDLE);
    res.done_res    = done;
    res.read_byte   = st_nxt.last_read;
    res.ack_missing = missing;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.op         <= OP_IDLE;
      st_r.phase      <= PH_0;
      st_r.bits_left  <= '0;
      st_r.shift_byte <= '0;
      st_r.wait_count <= '0;
      st_r.ack_choice <= 1'b0;
      st_r.scl        <= 1'b1;
      st_r.sda        <= 1'b1;
      st_r.drv        <= 1'b1;
      st_r.last_read  <= '0;
      st_r.stop_fail  <= 1'b0;
    end else if (step) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_data;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/i2cm_out_stage.sv]
`default_nettype none
module i2cm_out_stage import i2cm_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    item_valid,
  input  wire result_t res,
  input  wire logic    out_stall,
  output logic         out_valid,
  output result_t      out_res,
  output logic         step
);

  logic    valid_r;
  result_t res_r;

  // engine advances whenever an item is waiting and the result slot is free or draining
  assign step      = item_valid && (!valid_r || !out_stall);
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (step) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/i2c_master_bit_sequencer.sv]
// channel   direction  ports                                          handshake
// in        input      in_cmd in_write_byte in_send_ack in_sda_sample in_valid / in_stall
// out       output     out_scl_level .. out_ack_missing              out_valid / out_stall
// cfg       input      cfg_data (ack timeout limit)                   cfg_we, no wait
//
// one item per cycle sustained while out_stall is low; each item is one bus phase tick
// an item passes the input register, then the phase logic into the result register
// the phase engine state loop, st_r fed back through the phase logic, sets the rate
// synchronous active-low reset: bus lines high and driven, timeout limit 1000
// a stalled result blocks the engine; the input register takes a new item only while empty, then stalls
`default_nettype none
`include "assert_macros.svh"
module i2c_master_bit_sequencer import i2cm_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input items
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [2:0]           in_cmd,
  input  wire logic [BYTE_BITS-1:0] in_write_byte,
  input  wire logic                 in_send_ack,
  input  wire logic                 in_sda_sample,
  // result items
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_scl_level,
  output logic                      out_sda_level,
  output logic                      out_sda_drive,
  output logic                      out_busy_res,
  output logic                      out_done_res,
  output logic [BYTE_BITS-1:0]      out_read_byte,
  output logic                      out_ack_missing,
  // timeout limit register
  input  wire logic                 cfg_we,
  input  wire logic [LIMIT_W-1:0]   cfg_data
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    step;
  result_t res;
  result_t out_res;

  assign in_item.cmd        = in_cmd;
  assign in_item.write_byte = in_write_byte;
  assign in_item.send_ack   = in_send_ack;
  assign in_item.sda_sample = in_sda_sample;

  // input register
  i2cm_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .step       (step),
    .item_valid (item_valid),
    .item       (item)
  );

  // sequencer state and one phase of bus activity per item
  i2cm_phase_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .item     (item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .res      (res)
  );

  // result register, decides when the engine may advance
  i2cm_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .res        (res),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_res    (out_res),
    .step       (step)
  );

  assign out_scl_level   = out_res.scl_level;
  assign out_sda_level   = out_res.sda_level;
  assign out_sda_drive   = out_res.sda_drive;
  assign out_busy_res    = out_res.busy_res;
  assign out_done_res    = out_res.done_res;
  assign out_read_byte   = out_res.read_byte;
  assign out_ack_missing = out_res.ack_missing;

  // a finished operation leaves the sequencer idle
  `ASSERT_RST(a_done_not_busy, out_valid |-> !(out_done_res && out_busy_res), "done while busy")
  // missing ack is only reported on the closing tick of the forced stop
  `ASSERT_RST(a_missing_on_done, (out_valid && out_ack_missing) |-> out_done_res, "stray ack_missing")
  // a waiting item with a free result slot shows up in the result register in the following cycle
  `ASSERT_RST(a_item_moves, (item_valid && !out_valid) |=> out_valid, "item not advanced")

endmodule
`default_nettype wire
